[hw/rtl/mce_pkg.sv]
// shared types for the min merge cost engine
`timescale 1ns / 1ps

package mce_pkg;

   // sequencer states, one-hot
   typedef enum logic [11:0] {
      ST_LOAD     = 12'b0000_0000_0001,
      ST_UP_RD    = 12'b0000_0000_0010,
      ST_UP_CMP   = 12'b0000_0000_0100,
      ST_MCHK     = 12'b0000_0000_1000,
      ST_POP_A    = 12'b0000_0001_0000,
      ST_POP_LAST = 12'b0000_0010_0000,
      ST_DN_L     = 12'b0000_0100_0000,
      ST_DN_R     = 12'b0000_1000_0000,
      ST_DN_CMP   = 12'b0001_0000_0000,
      ST_READ_B   = 12'b0010_0000_0000,
      ST_GOT_B    = 12'b0100_0000_0000,
      ST_DONE     = 12'b1000_0000_0000
   } state_type;

endpackage

[hw/rtl/min_merge_cost_engine.sv]
// min merge cost engine: binary min-heap in ram under a small sequencer
//
// Usage: lengths arrive on the req_ channel, one per transfer. The transfer
// with req_last_item high closes the set and starts the merge. The block then
// repeatedly takes the two smallest values, adds their sum to the cost and
// puts the sum back, until one value is left, and offers the total cost and
// the overflow flag on the rsp_ channel as a single transfer.
// Loading: each length is pushed into the heap with a sift-up; req_ready
// is low meanwhile. Lengths beyond MAX_ITEMS are dropped and flag overflow.
// Merging: each merge is two root reads, one last-entry read and two
// sift-downs, all through the single read port of the heap ram; a set
// of n loaded values takes n-1 merges.
// A result waits in its output register until rsp_ready; while it waits,
// req_ready stays low. After the result transfer the block is empty again.
// Reset (synchronous, active high) empties the heap and clears cost and
// overflow; heap contents need no clearing since only live entries are read.
`timescale 1ns / 1ps

module min_merge_cost_engine #(
   parameter int MAX_ITEMS  = 256,
   parameter int VALUE_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_length_value,
   input  logic        req_last_item,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_total_cost,
   output logic        rsp_overflow
);

   import mce_pkg::*;

   localparam int IW = $clog2(MAX_ITEMS);
   localparam int CW = $clog2(MAX_ITEMS + 1);
   localparam int SW = VALUE_BITS + $clog2(MAX_ITEMS);
   localparam int XW = IW + 2;
   localparam logic [63:0] VMASK = (64'd1 << VALUE_BITS) - 64'd1;

   state_type       state_ff, state_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [IW-1:0]   pos_ff, pos_in;
   logic [SW-1:0]   cur_ff, cur_in;
   logic [SW-1:0]   lval_ff, lval_in;
   logic [SW-1:0]   aval_ff, aval_in;
   logic            hasr_ff, hasr_in;
   logic            phase_ff, phase_in;
   logic            last_ff, last_in;
   logic            ovf_ff, ovf_in;
   logic [31:0]     cost_ff, cost_in;

   logic            ram_wr_en;
   logic [IW-1:0]   ram_wr_addr;
   logic [SW-1:0]   ram_wr_data;
   logic            ram_rd_en;
   logic [IW-1:0]   ram_rd_addr;
   logic [SW-1:0]   ram_rd_data;

   logic [XW-1:0]   left_x;
   logic [XW-1:0]   right_x;
   logic [XW-1:0]   count_x;
   logic [IW-1:0]   parent;
   logic [15:0]     len_masked;
   logic [SW-1:0]   merge_sum;
   logic            has_room;

   // heap storage
   mce_ram #(
      .WIDTH (SW),
      .DEPTH (MAX_ITEMS)
   ) u_heap (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // heap index arithmetic
   assign left_x     = XW'({pos_ff, 1'b1});
   assign right_x    = left_x + XW'(1);
   assign count_x    = XW'(count_ff);
   assign parent     = IW'((pos_ff - IW'(1)) >> 1);
   assign len_masked = req_length_value & VMASK[15:0];
   assign merge_sum  = aval_ff + ram_rd_data;
   assign has_room   = count_ff < CW'(MAX_ITEMS);

   // sequencer
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      pos_in      = pos_ff;
      cur_in      = cur_ff;
      lval_in     = lval_ff;
      aval_in     = aval_ff;
      hasr_in     = hasr_ff;
      phase_in    = phase_ff;
      last_in     = last_ff;
      ovf_in      = ovf_ff;
      cost_in     = cost_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = pos_ff;
      ram_wr_data = cur_ff;
      ram_rd_en   = 1'b0;
      ram_rd_addr = '0;

      case (state_ff)
         // take one length; push it or drop it when full
         ST_LOAD: begin
            if (req_valid) begin
               last_in = req_last_item;
               if (has_room) begin
                  cur_in   = SW'(len_masked);
                  pos_in   = IW'(count_ff);
                  count_in = count_ff + CW'(1);
                  state_in = ST_UP_RD;
               end else begin
                  ovf_in = 1'b1;
                  if (req_last_item) begin
                     state_in = ST_MCHK;
                  end
               end
            end
         end

         // sift-up: fetch parent or settle at the root
         ST_UP_RD: begin
            if (pos_ff == '0) begin
               ram_wr_en = 1'b1;
               state_in  = last_ff ? ST_MCHK : ST_LOAD;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = parent;
               state_in    = ST_UP_CMP;
            end
         end

         // sift-up: move parent down or settle the new value
         ST_UP_CMP: begin
            ram_wr_en = 1'b1;
            if (ram_rd_data > cur_ff) begin
               ram_wr_data = ram_rd_data;
               pos_in      = parent;
               state_in    = ST_UP_RD;
            end else begin
               state_in = last_ff ? ST_MCHK : ST_LOAD;
            end
         end

         // merge loop head: more than one value left
         ST_MCHK: begin
            if (count_ff > CW'(1)) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = '0;
               state_in    = ST_POP_A;
            end else begin
               state_in = ST_DONE;
            end
         end

         // first minimum arrives; fetch the last entry
         ST_POP_A: begin
            aval_in     = ram_rd_data;
            ram_rd_en   = 1'b1;
            ram_rd_addr = IW'(count_ff - CW'(1));
            count_in    = count_ff - CW'(1);
            state_in    = ST_POP_LAST;
         end

         // last entry goes to the root hole
         ST_POP_LAST: begin
            cur_in   = ram_rd_data;
            pos_in   = '0;
            phase_in = 1'b0;
            state_in = ST_DN_L;
         end

         // sift-down: fetch left child or settle
         ST_DN_L: begin
            if (left_x >= count_x) begin
               ram_wr_en = 1'b1;
               state_in  = phase_ff ? ST_MCHK : ST_READ_B;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = IW'(left_x);
               state_in    = ST_DN_R;
            end
         end

         // sift-down: keep left child, fetch right child if present
         ST_DN_R: begin
            lval_in = ram_rd_data;
            hasr_in = right_x < count_x;
            if (right_x < count_x) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = IW'(right_x);
            end
            state_in = ST_DN_CMP;
         end

         // sift-down: move smaller child up or settle
         ST_DN_CMP: begin
            ram_wr_en = 1'b1;
            if (hasr_ff && (ram_rd_data < lval_ff)) begin
               if (ram_rd_data < cur_ff) begin
                  ram_wr_data = ram_rd_data;
                  pos_in      = IW'(right_x);
                  state_in    = ST_DN_L;
               end else begin
                  state_in = phase_ff ? ST_MCHK : ST_READ_B;
               end
            end else begin
               if (lval_ff < cur_ff) begin
                  ram_wr_data = lval_ff;
                  pos_in      = IW'(left_x);
                  state_in    = ST_DN_L;
               end else begin
                  state_in = phase_ff ? ST_MCHK : ST_READ_B;
               end
            end
         end

         // second minimum sits at the root
         ST_READ_B: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = '0;
            state_in    = ST_GOT_B;
         end

         // merge sum replaces the root and sinks
         ST_GOT_B: begin
            cost_in  = cost_ff + 32'(merge_sum);
            cur_in   = merge_sum;
            pos_in   = '0;
            phase_in = 1'b1;
            state_in = ST_DN_L;
         end

         // result waits for the transfer, then start a fresh set
         ST_DONE: begin
            if (rsp_ready) begin
               count_in = '0;
               cost_in  = '0;
               ovf_in   = 1'b0;
               last_in  = 1'b0;
               state_in = ST_LOAD;
            end
         end

         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         count_ff <= '0;
         cost_ff  <= '0;
         ovf_ff   <= 1'b0;
         last_ff  <= 1'b0;
         phase_ff <= 1'b0;
         hasr_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         cost_ff  <= cost_in;
         ovf_ff   <= ovf_in;
         last_ff  <= last_in;
         phase_ff <= phase_in;
         hasr_ff  <= hasr_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      pos_ff  <= pos_in;
      cur_ff  <= cur_in;
      lval_ff <= lval_in;
      aval_ff <= aval_in;
   end

   // ports
   assign req_ready      = (state_ff == ST_LOAD);
   assign rsp_valid      = (state_ff == ST_DONE);
   assign rsp_total_cost = cost_ff;
   assign rsp_overflow   = ovf_ff;

   // checks
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input taken while result pending");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_ITEMS))
      else $error("heap count beyond capacity");

   a_done_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> count_ff <= CW'(1))
      else $error("result offered with unmerged values");

   a_hole_in_heap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DN_L || state_ff == ST_UP_RD) |-> CW'(pos_ff) < count_ff)
      else $error("sift position outside heap");

   a_sum_after_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_GOT_B) |=> (state_ff == ST_DN_L && phase_ff))
      else $error("merge sum not sunk into heap");

endmodule

[hw/rtl/mce_ram.sv]
// generic single write, single read ram with registered read data
`timescale 1ns / 1ps

module mce_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[tb/min_merge_cost_engine_tb.sv]
// self-checking testbench for the min merge cost engine
`timescale 1ns / 1ps

module min_merge_cost_engine_tb;

   localparam int STORE_DEPTH = 256;
   localparam int LEN_BITS    = 16;
   localparam int ITEM_TARGET = 700;
   localparam int MIN_SETS    = 26;
   localparam int FULL_SET_NO = 10;
   localparam int OVER_SET_NO = 25;
   localparam int MAX_REPORTS = 10;

   // kinds of length mixes used for random sets
   typedef enum int {
      LEN_FULL,
      LEN_SMALL,
      LEN_EDGE,
      LEN_REPEAT
   } len_mix_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [15:0] req_length_value;
   logic        req_last_item;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_total_cost;
   logic        rsp_overflow;

   // no gaps on either side while set
   bit          quiet;
   int unsigned lengths_sent;

   // collects each set, predicts its merge cost and checks the results
   class merge_cost_checker;
      longint unsigned set_lengths[$];
      bit              set_dropped;
      logic [31:0]     expected_costs[$];
      logic            expected_overflows[$];
      int unsigned     errors;

      function void report(string msg);
         if (errors < MAX_REPORTS) $display("%0t: %s", $realtime, msg);
         errors++;
      endfunction

      // optimal merge cost: always merge the two smallest, cost wraps at 32 bits
      function logic [31:0] merge_cost(longint unsigned lens[$]);
         longint unsigned work[$];
         longint unsigned a, b, s;
         logic [31:0]     cost;
         int              pos;
         work = lens;
         work.sort();
         cost = '0;
         while (work.size() > 1) begin
            a = work.pop_front();
            b = work.pop_front();
            s = a + b;
            cost = cost + s[31:0];
            pos = 0;
            while (pos < work.size() && work[pos] < s) pos++;
            work.insert(pos, s);
         end
         return cost;
      endfunction

      function void note_length(logic [15:0] len, logic last);
         longint unsigned vmask;
         vmask = (64'd1 << LEN_BITS) - 1;
         if (set_lengths.size() < STORE_DEPTH) set_lengths.push_back(len & vmask);
         else set_dropped = 1'b1;
         if (last) begin
            expected_costs.push_back(merge_cost(set_lengths));
            expected_overflows.push_back(set_dropped);
            set_lengths.delete();
            set_dropped = 1'b0;
         end
      endfunction

      function void check_result(logic [31:0] cost, logic ovf);
         logic [31:0] want_cost;
         logic        want_ovf;
         if (expected_costs.size() == 0) begin
            report($sformatf("unexpected result: cost %0d overflow %0b", cost, ovf));
            return;
         end
         want_cost = expected_costs.pop_front();
         want_ovf  = expected_overflows.pop_front();
         if (cost !== want_cost)
            report($sformatf("total_cost mismatch: expected %0d, got %0d", want_cost, cost));
         if (ovf !== want_ovf)
            report($sformatf("overflow mismatch: expected %0b, got %0b", want_ovf, ovf));
      endfunction
   endclass

   merge_cost_checker costs;

   min_merge_cost_engine #(
      .MAX_ITEMS (STORE_DEPTH),
      .VALUE_BITS(LEN_BITS)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_length_value(req_length_value),
      .req_last_item   (req_last_item),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_total_cost  (rsp_total_cost),
      .rsp_overflow    (rsp_overflow)
   );

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // one length transfer; called and returns at a falling edge
   task automatic send_length(input logic [15:0] len, input logic last);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        = 1'b1;
      req_length_value = len;
      req_last_item    = last;
      do @(posedge clock); while (!req_ready);
      costs.note_length(len, last);
      lengths_sent++;
      @(negedge clock);
   endtask

   function automatic logic [15:0] pick_length(len_mix_type mix, logic [15:0] seed_len);
      case (mix)
         LEN_FULL:   return 16'($urandom_range(0, 65535));
         LEN_SMALL:  return 16'($urandom_range(0, 15));
         LEN_EDGE: begin
            case ($urandom_range(0, 2))
               0:       return 16'h0000;
               1:       return 16'hFFFF;
               default: return 16'($urandom_range(0, 65535));
            endcase
         end
         default:    return ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                                        : seed_len;
      endcase
   endfunction

   task automatic send_random_set(input int count);
      len_mix_type mix;
      logic [15:0] seed_len;
      mix      = len_mix_type'($urandom_range(0, 3));
      seed_len = 16'($urandom_range(0, 65535));
      for (int i = 0; i < count; i++)
         send_length(pick_length(mix, seed_len), i == count - 1);
   endtask

   // result side: ready either waits high or comes late after valid
   task automatic take_results();
      int stall;
      forever begin
         stall = quiet ? 0 : $urandom_range(0, 12);
         if (stall == 0) begin
            rsp_ready = 1'b1;
         end else begin
            rsp_ready = 1'b0;
            do @(posedge clock); while (!rsp_valid);
            repeat (stall) @(negedge clock);
            rsp_ready = 1'b1;
         end
         do @(posedge clock); while (!rsp_valid);
         costs.check_result(rsp_total_cost, rsp_overflow);
         @(negedge clock);
      end
   endtask

   // run limit
   initial begin
      #5_000_000;
      $display("min_merge_cost_engine regression: fail");
      $finish;
   end

   initial begin
      int set_no;
      int count;
      costs            = new();
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_length_value = '0;
      req_last_item    = 1'b0;
      rsp_ready        = 1'b0;
      quiet            = 1'b0;
      lengths_sent     = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      fork
         take_results();
      join_none

      // directed: single items give zero cost
      send_length(16'hFFFF, 1'b1);
      send_length(16'h0000, 1'b1);
      // largest pair
      send_length(16'hFFFF, 1'b0);
      send_length(16'hFFFF, 1'b1);
      // all zeros
      send_length(16'h0000, 1'b0);
      send_length(16'h0000, 1'b0);
      send_length(16'h0000, 1'b1);
      // ascending run, no idling
      quiet = 1'b1;
      for (int i = 1; i <= 5; i++) send_length(16'(i), i == 5);
      quiet = 1'b0;
      // four largest values
      for (int i = 0; i < 4; i++) send_length(16'hFFFF, i == 3);
      // alternating and complementary bit patterns
      send_length(16'h5555, 1'b0);
      send_length(16'hAAAA, 1'b0);
      send_length(16'h8000, 1'b0);
      send_length(16'h7FFF, 1'b1);

      // random sets, one exactly full and one past capacity
      set_no = 0;
      while (lengths_sent < ITEM_TARGET || set_no < MIN_SETS) begin
         if (set_no == FULL_SET_NO) count = STORE_DEPTH;
         else if (set_no == OVER_SET_NO) count = STORE_DEPTH + $urandom_range(1, 4);
         else if ($urandom_range(0, 9) == 0) count = $urandom_range(13, 40);
         else count = $urandom_range(1, 12);
         quiet = ($urandom_range(0, 3) == 0);
         send_random_set(count);
         set_no++;
      end
      quiet     = 1'b0;
      req_valid = 1'b0;

      // drain
      while (costs.expected_costs.size() > 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (costs.set_lengths.size() != 0) costs.report("lengths left without a closing item");

      if (costs.errors == 0 && costs.expected_costs.size() == 0) begin
         $display("min_merge_cost_engine regression: pass");
      end else begin
         $display("min_merge_cost_engine regression: fail");
      end
      $finish;
   end

endmodule

[sim.f]
hw/rtl/mce_pkg.sv
hw/rtl/mce_ram.sv
hw/rtl/min_merge_cost_engine.sv
tb/min_merge_cost_engine_tb.sv
